@@ hdl/ecbu_pkg.sv @@
// shared types and constants for the camera basis update block
`timescale 1ns / 1ps
`default_nettype none
package ecbu_pkg;

  localparam int unsigned YawFull    = 23040;
  localparam int unsigned YawHalf    = 11520;
  localparam int unsigned YawQuarter = 5760;
  localparam int          PitchLimit = 5696;
  localparam int          UnitQ14    = 16384;
  localparam int          AtanCount  = 24;
  localparam int          CordicGain = 163008219;
  localparam int          CwW        = 34;

  localparam logic CmdRotate = 1'b0;
  localparam logic CmdMove   = 1'b1;

  typedef enum logic [2:0] {
    RegSensitivity = 3'd0,
    RegMoveSpeed   = 3'd1,
    RegInitYaw     = 3'd2,
    RegInitPitch   = 3'd3,
    RegInitPosX    = 3'd4,
    RegInitPosY    = 3'd5,
    RegInitPosZ    = 3'd6,
    RegNone        = 3'd7
  } reg_idx_e;

  // one queued beat: command and its operands
  typedef struct packed {
    logic               cmd;
    logic signed [15:0] x_offset;
    logic signed [15:0] y_offset;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic        [15:0] delta_time;
  } ecbu_item_t;

  function automatic logic [21:0] atan_q16(input logic [4:0] idx);
    unique case (idx)
      5'd0: atan_q16 = 22'd2949120;
      5'd1: atan_q16 = 22'd1740967;
      5'd2: atan_q16 = 22'd919879;
      5'd3: atan_q16 = 22'd466945;
      5'd4: atan_q16 = 22'd234379;
      5'd5: atan_q16 = 22'd117304;
      5'd6: atan_q16 = 22'd58666;
      5'd7: atan_q16 = 22'd29335;
      5'd8: atan_q16 = 22'd14668;
      5'd9: atan_q16 = 22'd7334;
      5'd10: atan_q16 = 22'd3667;
      5'd11: atan_q16 = 22'd1833;
      5'd12: atan_q16 = 22'd917;
      5'd13: atan_q16 = 22'd458;
      5'd14: atan_q16 = 22'd229;
      5'd15: atan_q16 = 22'd115;
      5'd16: atan_q16 = 22'd57;
      5'd17: atan_q16 = 22'd29;
      5'd18: atan_q16 = 22'd14;
      5'd19: atan_q16 = 22'd7;
      5'd20: atan_q16 = 22'd4;
      5'd21: atan_q16 = 22'd2;
      5'd22: atan_q16 = 22'd1;
      default: atan_q16 = 22'd0;
    endcase
  endfunction

  // q28 to q14 with round and clamp
  function automatic logic signed [15:0] to_q14(input logic signed [CwW-1:0] v);
    logic signed [CwW:0] t;
    t = ($signed({v[CwW-1], v}) + (CwW+1)'(8192)) >>> 14;
    if (t > (CwW+1)'(UnitQ14)) to_q14 = 16'sd16384;
    else if (t < -(CwW+1)'(UnitQ14)) to_q14 = -16'sd16384;
    else to_q14 = t[15:0];
  endfunction

  function automatic logic signed [15:0] mul_q14(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [31:0] p;
    logic signed [31:0] t;
    p = a * b;
    t = (p + 32'sd8192) >>> 14;
    if (t > 32'sd16384) mul_q14 = 16'sd16384;
    else if (t < -32'sd16384) mul_q14 = -16'sd16384;
    else mul_q14 = t[15:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/ecbu_front.sv @@
// input stage and two-entry queue for incoming beats
`timescale 1ns / 1ps
`default_nettype none
module ecbu_front import ecbu_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  ecbu_item_t in_item_i,
  output logic       q_valid_o,
  input  wire        q_ready_i,
  output ecbu_item_t q_item_o
);

  ecbu_item_t  mem_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule
`default_nettype wire

@@ hdl/ecbu_cordic.sv @@
// iterative rotation-mode cordic for sine and cosine of a q.6 degree angle
`timescale 1ns / 1ps
`default_nettype none
module ecbu_cordic import ecbu_pkg::*; #(
  parameter int unsigned TrigSteps = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire signed [15:0] angle_i,
  output logic              done_o,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);

  localparam int unsigned Steps = (TrigSteps < AtanCount) ? TrigSteps : AtanCount;

  logic signed [CwW-1:0] x_q, y_q, x_d, y_d;
  logic signed [25:0]    z_q, z_d;
  logic                  flip_q;
  logic [4:0]            i_q;
  logic                  busy_q;
  logic signed [16:0]    a0, a1;
  logic                  fl;

  always_comb begin
    a0 = {angle_i[15], angle_i};
    if (a0 >= 17'sd11520) a0 = a0 - 17'sd23040;
    if (a0 < -17'sd11520) a0 = a0 + 17'sd23040;
    fl = 1'b0;
    a1 = a0;
    if (a0 > 17'sd5760) begin
      a1 = a0 - 17'sd11520;
      fl = 1'b1;
    end else if (a0 < -17'sd5760) begin
      a1 = a0 + 17'sd11520;
      fl = 1'b1;
    end
  end

  always_comb begin
    if (!z_q[25]) begin
      x_d = x_q - (y_q >>> i_q);
      y_d = y_q + (x_q >>> i_q);
      z_d = z_q - $signed({4'd0, atan_q16(i_q)});
    end else begin
      x_d = x_q + (y_q >>> i_q);
      y_d = y_q - (x_q >>> i_q);
      z_d = z_q + $signed({4'd0, atan_q16(i_q)});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      i_q    <= 5'd0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= 5'd0;
      end else if (busy_q) begin
        if (i_q == 5'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        i_q <= i_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CwW'(CordicGain);
      y_q    <= '0;
      z_q    <= 26'(a1) <<< 10;
      flip_q <= fl;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign sin_o = to_q14(flip_q ? -y_q : y_q);
  assign cos_o = to_q14(flip_q ? -x_q : x_q);

endmodule
`default_nettype wire

@@ hdl/ecbu_back.sv @@
// executes beats: angle and position update, trig, basis products, output register
`timescale 1ns / 1ps
`default_nettype none
module ecbu_back import ecbu_pkg::*; #(
  parameter int unsigned TrigSteps = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               q_valid_i,
  output logic              q_ready_o,
  input  ecbu_item_t        q_item_i,
  input  wire        [15:0] sensitivity_i,
  input  wire        [15:0] move_speed_i,
  input  wire               ld_yaw_i,
  input  wire        [14:0] ld_yaw_val_i,
  input  wire               ld_pitch_i,
  input  wire signed [13:0] ld_pitch_val_i,
  input  wire        [2:0]  ld_pos_i,
  input  wire signed [23:0] ld_pos_val_i,
  output logic              busy_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic signed [15:0] front_x_o, front_y_o, front_z_o,
  output logic signed [15:0] right_x_o, right_y_o, right_z_o,
  output logic signed [15:0] up_x_o, up_y_o, up_z_o,
  output logic signed [23:0] pos_x_o, pos_y_o, pos_z_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StUpd   = 7'b0000010,
    StApply = 7'b0000100,
    StYaw   = 7'b0001000,
    StPitch = 7'b0010000,
    StMul   = 7'b0100000,
    StOut   = 7'b1000000
  } st_e;

  st_e state_q, state_d;
  logic [14:0]        yaw_q;
  logic signed [13:0] pitch_q;
  logic signed [23:0] pos_q [3];
  ecbu_item_t         item_q;
  logic signed [31:0] dyaw_q, dpitch_q;
  logic        [31:0] vel_q;
  logic signed [15:0] sy_q, cy_q, sp_q, cp_q;
  logic [1:0]         k_q;
  logic signed [48:0] mv_q;

  logic               cs_start, cs_done;
  logic signed [15:0] cs_angle, cs_sin, cs_cos;

  // queue pops only when idle and output slot free
  assign q_ready_o = (state_q == StIdle) && !out_valid_o;
  assign busy_o    = (state_q != StIdle);

  ecbu_cordic #(.TrigSteps(TrigSteps)) u_cordic (
    .clk_i, .rst_ni, .start_i(cs_start), .angle_i(cs_angle),
    .done_o(cs_done), .sin_o(cs_sin), .cos_o(cs_cos)
  );

  assign cs_start = (state_q == StApply && k_q == 2'd3)
                 || (state_q == StYaw && cs_done);
  assign cs_angle = (state_q == StApply) ? $signed({1'b0, yaw_q})
                                          : 16'(pitch_q);

  logic signed [23:0] dir_sel;
  always_comb begin
    unique case (k_q)
      2'd0: dir_sel = 24'(item_q.dir_x);
      2'd1: dir_sel = 24'(item_q.dir_y);
      default: dir_sel = 24'(item_q.dir_z);
    endcase
  end

  logic signed [18:0] yaw_sum;
  logic        [19:0] yaw_m0, yaw_m1, yaw_m2, yaw_m3, yaw_m4;
  logic        [14:0] yaw_w;
  logic signed [18:0] pit_sum;
  logic signed [25:0] pos_sum;
  logic signed [18:0] mstep;
  logic signed [31:0] mrnd;
  logic [1:0]         kk;

  always_comb begin
    yaw_sum = $signed({4'b0, yaw_q}) + $signed(dyaw_q[18:0]);
    // six turns up keeps the sum positive, then strip whole turns
    yaw_m0 = 20'(yaw_sum) + 20'(YawFull * 6);
    yaw_m1 = (yaw_m0 >= 20'(YawFull * 8)) ? yaw_m0 - 20'(YawFull * 8) : yaw_m0;
    yaw_m2 = (yaw_m1 >= 20'(YawFull * 4)) ? yaw_m1 - 20'(YawFull * 4) : yaw_m1;
    yaw_m3 = (yaw_m2 >= 20'(YawFull * 2)) ? yaw_m2 - 20'(YawFull * 2) : yaw_m2;
    yaw_m4 = (yaw_m3 >= 20'(YawFull)) ? yaw_m3 - 20'(YawFull) : yaw_m3;
    yaw_w = yaw_m4[14:0];
    pit_sum = 19'(pitch_q) + $signed(dpitch_q[18:0]);
    mrnd = 32'((mv_q + 49'sd536870912) >>> 30);
    mstep = mrnd[18:0];
    kk = k_q - 2'd1;
    pos_sum = 26'(pos_q[kk]) + 26'(mstep);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_o <= 1'b0;
      yaw_q       <= '0;
      pitch_q     <= '0;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      pos_q[2]    <= '0;
      k_q         <= '0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (ld_yaw_i) yaw_q <= (ld_yaw_val_i >= 15'(YawFull))
                          ? ld_yaw_val_i - 15'(YawFull) : ld_yaw_val_i;
      if (ld_pitch_i) begin
        if (ld_pitch_val_i > 14'sd5696) pitch_q <= 14'sd5696;
        else if (ld_pitch_val_i < -14'sd5696) pitch_q <= -14'sd5696;
        else pitch_q <= ld_pitch_val_i;
      end
      for (int j = 0; j < 3; j++) begin
        if (ld_pos_i[j]) pos_q[j] <= ld_pos_val_i;
      end
      unique case (state_q)
        StIdle: begin
          if (q_valid_i && q_ready_o) state_q <= StUpd;
          k_q <= 2'd0;
        end
        StUpd: state_q <= StApply;
        StApply: begin
          if (item_q.cmd == CmdRotate) begin
            if (k_q == 2'd0) begin
              yaw_q <= yaw_w;
              if (pit_sum > 19'sd5696) pitch_q <= 14'sd5696;
              else if (pit_sum < -19'sd5696) pitch_q <= -14'sd5696;
              else pitch_q <= pit_sum[13:0];
              k_q <= 2'd3;
            end else begin
              state_q <= StYaw;
              k_q     <= 2'd0;
            end
          end else begin
            if (k_q != 2'd0) begin
              if (pos_sum > 26'sd8388607) pos_q[kk] <= 24'sh7fffff;
              else if (pos_sum < -26'sd8388608) pos_q[kk] <= 24'sh800000;
              else pos_q[kk] <= pos_sum[23:0];
            end
            if (k_q == 2'd3) state_q <= StYaw;
            k_q <= k_q + 2'd1;
          end
        end
        StYaw: if (cs_done) state_q <= StPitch;
        StPitch: if (cs_done) state_q <= StMul;
        StMul: state_q <= StOut;
        StOut: begin
          out_valid_o <= 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) item_q <= q_item_i;
    if (state_q == StUpd) begin
      dyaw_q   <= (32'(item_q.x_offset) * $signed({16'd0, sensitivity_i}) + 32'sd8192) >>> 14;
      dpitch_q <= (32'(item_q.y_offset) * $signed({16'd0, sensitivity_i}) + 32'sd8192) >>> 14;
      vel_q    <= move_speed_i * item_q.delta_time;
    end
    if (state_q == StApply) mv_q <= 49'(dir_sel) * $signed({17'd0, vel_q});
    if (state_q == StYaw && cs_done) begin
      sy_q <= cs_sin;
      cy_q <= cs_cos;
    end
    if (state_q == StPitch && cs_done) begin
      sp_q <= cs_sin;
      cp_q <= cs_cos;
    end
    if (state_q == StMul) begin
      front_x_o <= mul_q14(cy_q, cp_q);
      front_y_o <= sp_q;
      front_z_o <= mul_q14(sy_q, cp_q);
      right_x_o <= -sy_q;
      right_y_o <= '0;
      right_z_o <= cy_q;
      up_x_o    <= -mul_q14(cy_q, sp_q);
      up_y_o    <= cp_q;
      up_z_o    <= -mul_q14(sy_q, sp_q);
      pos_x_o   <= pos_q[0];
      pos_y_o   <= pos_q[1];
      pos_z_o   <= pos_q[2];
    end
  end

endmodule
`default_nettype wire

@@ hdl/euler_camera_basis_update_unit.sv @@
// top level of the first-person camera basis update block
// usage:
//   input channel in_valid_i/in_ready_o carries a rotate or move beat (cmd_i)
//   output channel out_valid_o/out_ready_i returns front, right, up and position
//   the apb port sets sensitivity, speed and loads yaw, pitch and position
// sequence:
//   an item passes the update, apply, yaw trig, pitch trig, product and output states
//   from queue exit to result; the single shared cordic serves yaw and pitch in turn
// throughput:
//   one item at a time in the back end; a two-beat queue in front keeps
//   accepting while a result waits or the back end is busy
// reset:
//   yaw, pitch and position clear to zero; registers take their defaults
// stall:
//   a held result blocks the back end, the queue fills, then in_ready_o drops
`timescale 1ns / 1ps
`default_nettype none
module euler_camera_basis_update_unit import ecbu_pkg::*; #(
  parameter int unsigned TRIG_STEPS = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire        [4:0]  paddr,
  input  wire        [31:0] pwdata,
  output logic       [31:0] prdata,
  output logic              pready,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire               cmd_i,
  input  wire signed [15:0] x_offset_i,
  input  wire signed [15:0] y_offset_i,
  input  wire signed [15:0] dir_x_i,
  input  wire signed [15:0] dir_y_i,
  input  wire signed [15:0] dir_z_i,
  input  wire        [15:0] delta_time_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic signed [15:0] front_x_o,
  output logic signed [15:0] front_y_o,
  output logic signed [15:0] front_z_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_y_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o,
  output logic signed [23:0] pos_x_o,
  output logic signed [23:0] pos_y_o,
  output logic signed [23:0] pos_z_o
);

  logic [15:0] sens_q, speed_q;
  logic [14:0] iyaw_q;
  logic [13:0] ipitch_q;
  logic [23:0] ipx_q, ipy_q, ipz_q;
  logic        wr;
  reg_idx_e    ridx;
  ecbu_item_t  in_item, q_item;
  logic        q_valid, q_ready, busy;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = (paddr[4:2] == 3'd7) ? RegNone : reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q   <= 16'd6554;
      speed_q  <= 16'd2560;
      iyaw_q   <= '0;
      ipitch_q <= '0;
      ipx_q    <= '0;
      ipy_q    <= '0;
      ipz_q    <= '0;
    end else if (wr) begin
      unique case (ridx)
        RegSensitivity: sens_q   <= pwdata[15:0];
        RegMoveSpeed:   speed_q  <= pwdata[15:0];
        RegInitYaw:     iyaw_q   <= pwdata[14:0];
        RegInitPitch:   ipitch_q <= pwdata[13:0];
        RegInitPosX:    ipx_q    <= pwdata[23:0];
        RegInitPosY:    ipy_q    <= pwdata[23:0];
        RegInitPosZ:    ipz_q    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegSensitivity: prdata = {16'd0, sens_q};
      RegMoveSpeed:   prdata = {16'd0, speed_q};
      RegInitYaw:     prdata = {17'd0, iyaw_q};
      RegInitPitch:   prdata = {18'd0, ipitch_q};
      RegInitPosX:    prdata = {8'd0, ipx_q};
      RegInitPosY:    prdata = {8'd0, ipy_q};
      RegInitPosZ:    prdata = {8'd0, ipz_q};
      default:        prdata = '0;
    endcase
  end

  assign in_item = '{cmd: cmd_i, x_offset: x_offset_i, y_offset: y_offset_i,
                     dir_x: dir_x_i, dir_y: dir_y_i, dir_z: dir_z_i,
                     delta_time: delta_time_i};

  ecbu_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  ecbu_back #(.TrigSteps(TRIG_STEPS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .sensitivity_i(sens_q), .move_speed_i(speed_q),
    .ld_yaw_i(wr && ridx == RegInitYaw), .ld_yaw_val_i(pwdata[14:0]),
    .ld_pitch_i(wr && ridx == RegInitPitch), .ld_pitch_val_i(pwdata[13:0]),
    .ld_pos_i({wr && ridx == RegInitPosZ, wr && ridx == RegInitPosY,
               wr && ridx == RegInitPosX}),
    .ld_pos_val_i(pwdata[23:0]),
    .busy_o(busy),
    .out_valid_o, .out_ready_i,
    .front_x_o, .front_y_o, .front_z_o,
    .right_x_o, .right_y_o, .right_z_o,
    .up_x_o, .up_y_o, .up_z_o,
    .pos_x_o, .pos_y_o, .pos_z_o
  );

`ifndef SYNTHESIS
  a_right_y_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> right_y_o == 16'sd0) else $error("right_y not zero");
  a_no_pop_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !q_ready) else $error("queue popped while busy");
  a_front_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (front_y_o <= 16'sd16384 && front_y_o >= -16'sd16384))
    else $error("front_y out of range");
`endif

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking testbench for the camera basis update block
`timescale 1ns / 1ps
module tb_top;
  import ecbu_pkg::*;

  localparam int unsigned Steps = 16;
  localparam int MaxCycles = 2000000;

  typedef struct {
    logic               cmd;
    logic signed [15:0] xo, yo, dx, dy, dz;
    logic        [15:0] dt;
  } beat_t;

  typedef struct {
    logic signed [15:0] v [9];
    logic signed [23:0] p [3];
  } basis_t;

  typedef struct {
    beat_t  b;
    logic   known;
    basis_t r;
  } row_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0, out_ready_i = 1'b0;
  logic cmd_i = 1'b0;
  logic signed [15:0] x_offset_i = '0, y_offset_i = '0;
  logic signed [15:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic [15:0] delta_time_i = '0;
  logic in_ready_o, out_valid_o;
  logic signed [15:0] front_x_o, front_y_o, front_z_o, right_x_o, right_y_o, right_z_o;
  logic signed [15:0] up_x_o, up_y_o, up_z_o;
  logic signed [23:0] pos_x_o, pos_y_o, pos_z_o;

  euler_camera_basis_update_unit #(.TRIG_STEPS(Steps)) dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // camera state held by the predictor
  longint sens, speed, yaw, pitch;
  longint pos [3];
  basis_t basis_q[$];
  int errors = 0, cycles = 0, n_items = 0, n_results = 0, n_cfg = 0;
  bit long_stall = 0;

  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mod_yaw(longint a);
    longint r;
    r = a % longint'(YawFull);
    if (r < 0) r += longint'(YawFull);
    return r;
  endfunction

  function automatic longint atan_deg(int i);
    longint t [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                       14668, 7334, 3667, 1833, 917, 458, 229, 115,
                       57, 29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  task automatic cordic(input longint ang, output longint s, output longint c);
    longint x, y, z, nx, a;
    bit flip;
    x = CordicGain; y = 0; flip = 0;
    a = ang % longint'(YawFull);
    if (a >= longint'(YawHalf)) a -= longint'(YawFull);
    if (a < -longint'(YawHalf)) a += longint'(YawFull);
    if (a > longint'(YawQuarter)) begin
      a -= longint'(YawHalf); flip = 1;
    end else if (a < -longint'(YawQuarter)) begin
      a += longint'(YawHalf); flip = 1;
    end
    z = a * 1024;
    for (int i = 0; i < Steps && i < AtanCount; i++) begin
      if (z >= 0) begin
        nx = x - fl_shr(y, i); y = y + fl_shr(x, i); z -= atan_deg(i);
      end else begin
        nx = x + fl_shr(y, i); y = y - fl_shr(x, i); z += atan_deg(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = clip(fl_shr(y + 8192, 14), -UnitQ14, UnitQ14);
    c = clip(fl_shr(x + 8192, 14), -UnitQ14, UnitQ14);
  endtask

  function automatic longint qmul(longint a, longint b);
    return clip(fl_shr(a * b + 8192, 14), -UnitQ14, UnitQ14);
  endfunction

  task automatic advance_camera(input beat_t b, output basis_t r);
    longint sy, cy, sp, cp, vel, d;
    if (b.cmd == CmdRotate) begin
      yaw = mod_yaw(yaw + fl_shr(longint'(b.xo) * sens + 8192, 14));
      pitch = clip(pitch + fl_shr(longint'(b.yo) * sens + 8192, 14), -PitchLimit, PitchLimit);
    end else begin
      vel = speed * longint'(b.dt);
      for (int k = 0; k < 3; k++) begin
        d = k == 0 ? b.dx : (k == 1 ? b.dy : b.dz);
        pos[k] = clip(pos[k] + fl_shr(d * vel + (longint'(1) << 29), 30), -8388608, 8388607);
      end
    end
    cordic(yaw, sy, cy);
    cordic(pitch, sp, cp);
    r.v[0] = 16'(qmul(cy, cp)); r.v[1] = 16'(sp); r.v[2] = 16'(qmul(sy, cp));
    r.v[3] = 16'(-sy); r.v[4] = 16'(0); r.v[5] = 16'(cy);
    r.v[6] = 16'(-qmul(cy, sp)); r.v[7] = 16'(cp); r.v[8] = 16'(-qmul(sy, sp));
    for (int k = 0; k < 3; k++) r.p[k] = 24'(pos[k]);
  endtask

  function automatic int gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  task automatic reg_write(input reg_idx_e idx, input longint val);
    @(negedge clk_i);
    psel = 1; penable = 0; pwrite = 1; paddr = 5'(4 * idx); pwdata = 32'(val);
    @(negedge clk_i);
    penable = 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
    n_cfg++;
    case (idx)
      RegSensitivity: sens = val & 16'hffff;
      RegMoveSpeed:   speed = val & 16'hffff;
      RegInitYaw:     yaw = mod_yaw(val & 15'h7fff);
      RegInitPitch:   pitch = clip(longint'($signed(14'(val))), -PitchLimit, PitchLimit);
      RegInitPosX:    pos[0] = longint'($signed(24'(val)));
      RegInitPosY:    pos[1] = longint'($signed(24'(val)));
      RegInitPosZ:    pos[2] = longint'($signed(24'(val)));
      default: ;
    endcase
  endtask

  task automatic send(input beat_t b);
    basis_t r;
    repeat (gap()) @(negedge clk_i);
    in_valid_i = 1;
    cmd_i = b.cmd; x_offset_i = b.xo; y_offset_i = b.yo;
    dir_x_i = b.dx; dir_y_i = b.dy; dir_z_i = b.dz; delta_time_i = b.dt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_camera(b, r);
    basis_q.push_back(r);
    n_items++;
    @(negedge clk_i);
    in_valid_i = 0;
  endtask

  task automatic drain();
    while (basis_q.size() != 0) @(negedge clk_i);
    repeat (4 * Steps + 40) @(negedge clk_i);
  endtask

  function automatic beat_t rand_beat();
    beat_t b;
    b.cmd = 1'($urandom_range(0, 1));
    b.xo = 16'($urandom); b.yo = 16'($urandom);
    if ($urandom_range(0, 2) != 0) begin
      b.xo = 16'($signed(16'($urandom_range(0, 1600))) - 800);
      b.yo = 16'($signed(16'($urandom_range(0, 1600))) - 800);
    end
    b.dx = 16'($signed(16'($urandom_range(0, 32768))) - 16384);
    b.dy = 16'($signed(16'($urandom_range(0, 32768))) - 16384);
    b.dz = 16'($signed(16'($urandom_range(0, 32768))) - 16384);
    b.dt = 16'($urandom);
    return b;
  endfunction

  // receiver with random back-pressure
  initial begin
    int w;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) out_ready_i = 0;
      else if (long_stall) out_ready_i = 0;
      else begin
        w = gap();
        out_ready_i = (w == 0) || ($urandom_range(0, 1) == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    basis_t e;
    logic signed [15:0] got [9];
    logic signed [23:0] gp [3];
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{front_x_o, front_y_o, front_z_o, right_x_o, right_y_o, right_z_o,
              up_x_o, up_y_o, up_z_o};
      gp = '{pos_x_o, pos_y_o, pos_z_o};
      n_results++;
      if (basis_q.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
      end else begin
        e = basis_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== e.v[k]) begin
            $display("%0t: vector field %0d expected %0d got %0d", $time, k, e.v[k], got[k]);
            errors++;
          end
        for (int k = 0; k < 3; k++)
          if (gp[k] !== e.p[k]) begin
            $display("%0t: pos field %0d expected %0d got %0d", $time, k, e.p[k], gp[k]);
            errors++;
          end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  row_t plan [$];

  function automatic row_t mk(logic c, int xo, int yo, int dx, int dy, int dz, int dt);
    row_t r;
    r.b = '{c, 16'(xo), 16'(yo), 16'(dx), 16'(dy), 16'(dz), 16'(dt)};
    r.known = 0;
    return r;
  endfunction

  initial begin
    row_t r;
    basis_t rr;
    sens = 6554; speed = 2560; yaw = 0; pitch = 0; pos = '{0, 0, 0};
    repeat (7) @(negedge clk_i);
    rst_ni = 1;

    // straight ahead after reset: front +x, right +z, up +y
    r = mk(CmdRotate, 0, 0, 0, 0, 0, 0);
    r.known = 1;
    r.r.v = '{16384, 0, 0, 0, 0, 16384, 0, 16384, 0};
    r.r.p = '{0, 0, 0};
    plan.push_back(r);
    plan.push_back(mk(CmdRotate, 32767, 32767, 0, 0, 0, 0));
    plan.push_back(mk(CmdRotate, -32768, -32768, 0, 0, 0, 0));
    plan.push_back(mk(CmdRotate, 32767, 0, -1, -1, -1, 65535));
    plan.push_back(mk(CmdRotate, -1, 1, 16384, -16384, 16384, 65535));
    plan.push_back(mk(CmdMove, 32767, -32768, 16384, 16384, 16384, 65535));
    plan.push_back(mk(CmdMove, 0, 0, -16384, -16384, -16384, 65535));
    plan.push_back(mk(CmdMove, 0, 0, 16384, -16384, 0, 0));
    plan.push_back(mk(CmdMove, -1, -1, 1, -1, 0, 1));
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].known) begin
        advance_camera(plan[i].b, rr);
        yaw = 0; pitch = 0; pos = '{0, 0, 0};
        if (rr.v != plan[i].r.v || rr.p != plan[i].r.p) begin
          $display("%0t: table row %0d disagrees with predictor", $time, i);
          errors++;
        end
      end
      send(plan[i].b);
    end
    drain();

    // extremes: saturating position, out-of-range yaw and pitch loads
    reg_write(RegMoveSpeed, 16'hffff);
    reg_write(RegSensitivity, 16'hffff);
    reg_write(RegInitYaw, 15'h7fff);
    reg_write(RegInitPitch, 14'h1fff);
    reg_write(RegInitPosX, 24'h7ffff0);
    reg_write(RegInitPosY, 24'h800010);
    reg_write(RegInitPosZ, 24'h000000);
    reg_write(RegNone, 32'hffffffff);
    for (int i = 0; i < 6; i++) begin
      send('{CmdMove, 16'(0), 16'(0), 16'sd16384, -16'sd16384, 16'sd16384, 16'hffff});
      send('{CmdRotate, 16'h7fff, 16'h7fff, 16'(0), 16'(0), 16'(0), 16'(0)});
    end
    drain();
    reg_write(RegInitPitch, 14'h2000);
    reg_write(RegSensitivity, 0);
    reg_write(RegMoveSpeed, 0);
    send('{CmdRotate, 16'h7fff, 16'h8000, 16'(0), 16'(0), 16'(0), 16'(0)});
    send('{CmdMove, 16'(0), 16'(0), 16'sd16384, 16'sd16384, 16'sd16384, 16'hffff});
    drain();

    // random phases under differing settings
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(RegSensitivity, $urandom_range(0, 65535));
      reg_write(RegMoveSpeed, ph == 0 ? 65535 : $urandom_range(0, 65535));
      reg_write(RegInitYaw, $urandom_range(0, 32767));
      reg_write(RegInitPitch, $urandom_range(0, 16383));
      reg_write(RegInitPosX, $urandom);
      reg_write(RegInitPosY, $urandom);
      reg_write(RegInitPosZ, $urandom);
      for (int i = 0; i < 50; i++) begin
        // receiver holds off for a while so the queue fills
        if (i == 25) begin
          fork
            begin
              long_stall = 1;
              repeat (200) @(negedge clk_i);
              long_stall = 0;
            end
          join_none
        end
        send(rand_beat());
      end
      drain();
    end
    reg_write(RegSensitivity, 6554);
    reg_write(RegMoveSpeed, 2560);

    $display("covered %0d input beats, %0d result beats, %0d register writes",
             n_items, n_results, n_cfg);
    $display("directed extremes, saturation, wrap, clamp and random phases under back-pressure");
    if (errors == 0 && basis_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
